// ===== rtl/core/ascii_decimal_line_parser_defines.svh =====
// Assertion macros shared by the line parser RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASCII_DECIMAL_LINE_PARSER_DEFINES_SVH
`define ASCII_DECIMAL_LINE_PARSER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define ADLP_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("adlp: invariant violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ADLP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adlp: same-cycle implication violated");

// When the antecedent holds, the consequent must hold in the cycle after.
`define ADLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adlp: next-cycle implication violated");

`endif

// ===== rtl/core/adlp_pkg.sv =====
package adlp_pkg;

   // Byte codes the parser recognizes.
   localparam logic [7:0] ByteTab     = 8'd9;
   localparam logic [7:0] ByteNewline = 8'd10;
   localparam logic [7:0] ByteCr      = 8'd13;
   localparam logic [7:0] ByteSpace   = 8'd32;
   localparam logic [7:0] BytePlus    = 8'd43;
   localparam logic [7:0] ByteMinus   = 8'd45;
   localparam logic [7:0] ByteDigit0  = 8'd48;
   localparam logic [7:0] ByteDigit9  = 8'd57;

   // Saturation limits of the magnitude for each sign.
   localparam logic [31:0] PosLimit = 32'h7FFF_FFFF;
   localparam logic [31:0] NegLimit = 32'h8000_0000;

   // Parse phase within one line.
   typedef enum logic [3:0] {
      PhaseSkip   = 4'b0001,
      PhaseSign   = 4'b0010,
      PhaseDigits = 4'b0100,
      PhaseStop   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic               number_found;
   } rsp_payload_type;

endpackage

// ===== rtl/core/adlp_stream_if.sv =====
// Valid/ready channel carrying one payload per beat.
interface adlp_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/adlp_parse_core.sv =====
`include "ascii_decimal_line_parser_defines.svh"

module adlp_parse_core #(
   parameter int LINE_BYTES = 100
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               rx_byte,
   output adlp_pkg::rsp_payload_type line_result
);
   import adlp_pkg::*;

   localparam int CountWidth = $clog2(LINE_BYTES);

   logic [31:0]           held_ff, held_in;
   logic [CountWidth-1:0] count_ff, count_in;
   phase_type             phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           acc_ff, acc_in;
   logic                  sat_ff, sat_in;
   logic                  seen_ff, seen_in;

   logic                  is_digit;
   logic                  is_blank;
   logic                  take;
   logic [CountWidth:0]   count_inc;
   logic [35:0]           acc_wide;
   logic [35:0]           prod;
   logic [35:0]           limit;
   logic [31:0]           line_value;

   // Byte classes.
   assign is_digit = rx_byte inside {[ByteDigit0:ByteDigit9]};
   assign is_blank = rx_byte inside {ByteSpace, [ByteTab:ByteCr]};

   // Accumulator times ten plus the new digit, compared with the limit for the sign.
   assign acc_wide = {4'd0, acc_ff};
   assign prod     = (acc_wide << 3) + (acc_wide << 1) + {32'd0, rx_byte[3:0]};
   assign limit    = {4'd0, (neg_ff ? NegLimit : PosLimit)};

   assign count_inc  = {1'b0, count_ff} + {{CountWidth{1'b0}}, 1'b1};
   assign line_value = neg_ff ? (32'd0 - acc_ff) : acc_ff;

   // The result a newline in this cycle produces.
   assign line_result.number_found = seen_ff;
   assign line_result.position     = seen_ff ? line_value : held_ff;

   // Next-state logic for one byte.
   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      seen_in  = seen_ff;
      take     = 1'b0;

      case (phase_ff)
         PhaseSkip: begin
            if (!is_blank) begin
               if (rx_byte == BytePlus || rx_byte == ByteMinus) begin
                  neg_in   = (rx_byte == ByteMinus);
                  phase_in = PhaseSign;
               end else if (is_digit) begin
                  take = 1'b1;
               end else begin
                  phase_in = PhaseStop;
               end
            end
         end
         PhaseSign, PhaseDigits: begin
            if (is_digit) begin
               take = 1'b1;
            end else begin
               phase_in = PhaseStop;
            end
         end
         PhaseStop: begin
            phase_in = PhaseStop;
         end
         default: begin
            phase_in = PhaseStop;
         end
      endcase

      // Fold in a digit; once saturated, the magnitude stays at the limit.
      if (take) begin
         seen_in  = 1'b1;
         phase_in = PhaseDigits;
         if (!sat_ff) begin
            if (prod >= limit) begin
               acc_in = limit[31:0];
               sat_in = 1'b1;
            end else begin
               acc_in = prod[31:0];
            end
         end
      end

      // A newline closes the line; a full buffer restarts it from empty.
      if (rx_byte == ByteNewline || count_inc == (CountWidth + 1)'(LINE_BYTES)) begin
         if (rx_byte == ByteNewline) begin
            held_in = line_result.position;
         end
         count_in = '0;
         phase_in = PhaseSkip;
         neg_in   = 1'b0;
         acc_in   = '0;
         sat_in   = 1'b0;
         seen_in  = 1'b0;
      end else begin
         count_in = count_inc[CountWidth-1:0];
      end
   end

   // Line state advances once per byte taken from the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         count_ff <= '0;
         phase_ff <= PhaseSkip;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (step_en) begin
         held_ff  <= held_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
         seen_ff  <= seen_in;
      end
   end

   // The magnitude never exceeds the negative limit.
   `ADLP_ASSERT_ALWAYS(a_acc_bounded, acc_ff <= NegLimit)
   // A saturated magnitude sits exactly on the limit for its sign.
   `ADLP_ASSERT_SAME(a_sat_at_limit, sat_ff, acc_ff == (neg_ff ? NegLimit : PosLimit))
   // Digits seen means the phase has moved to taking digits or stopped.
   `ADLP_ASSERT_SAME(a_seen_phase, seen_ff, phase_ff == PhaseDigits || phase_ff == PhaseStop)

endmodule

// ===== rtl/core/ascii_decimal_line_parser.sv =====
// ASCII decimal line parser.
// The req_if channel takes one received byte per beat; the rsp_if channel gives one
// beat per newline byte with the held position and a flag that tells whether the
// line held digits. Each line is read as a signed decimal integer: leading blanks
// are skipped, one optional sign is taken, then digits up to the first other byte.
// Magnitudes beyond the 32-bit signed range saturate. A line of LINE_BYTES bytes
// without a newline restarts the parse from empty.
// Path: an accepted newline waits in the input register until the result register
// is free, then the parse logic loads its result into the result register, from
// which the receiver takes its beat.
// Throughput: one byte per cycle, set by the times-ten accumulator, unless stalled.
// A byte that produces no result never waits on the output side. When the
// receiver stalls with a result pending, the next newline waits in the input
// register and req_if.ready drops; other bytes keep flowing.
// Reset (synchronous, active high) clears the held position to zero, empties both
// registers and returns the parser to the start of a line.
`include "ascii_decimal_line_parser_defines.svh"

module ascii_decimal_line_parser #(
   parameter int LINE_BYTES = 100
) (
   input  logic          clock,
   input  logic          reset,
   adlp_stream_if.sink   req_if,
   adlp_stream_if.source rsp_if
);
   import adlp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            in_newline;
   logic            out_free;
   logic            advance;
   logic            emit;
   rsp_payload_type line_result;

   // Handshake control between the input register and the result register.
   assign in_newline = (in_byte_ff == ByteNewline);
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign advance    = in_valid_ff && (!in_newline || out_free);
   assign emit       = advance && in_newline;

   assign req_if.ready   = !in_valid_ff || advance;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   adlp_parse_core #(
      .LINE_BYTES (LINE_BYTES)
   ) u_parse_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .rx_byte     (in_byte_ff),
      .line_result (line_result)
   );

   // Next values of the input and result registers.
   always_comb begin
      in_valid_in    = in_valid_ff;
      in_byte_in     = in_byte_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
         in_byte_in  = req_if.payload.rx_byte;
      end
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = line_result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control bits reset; payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // A newline that leaves the input register always lands in the result register.
   `ADLP_ASSERT_NEXT(a_emit_lands, emit, rsp_valid_ff)
   // Input backpressure only arises from a byte held in the input register.
   `ADLP_ASSERT_SAME(a_stall_cause, !req_if.ready, in_valid_ff && in_newline && !out_free)
   // A held byte that did not advance is still held in the next cycle.
   `ADLP_ASSERT_NEXT(a_hold_input, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule

// ===== test/testbench.sv =====
module testbench;
   import adlp_pkg::*;

   localparam int LINE_LIMIT = 100;
   // Generous bound on the whole run, far above the slowest legal run.
   localparam int RUN_LIMIT = 5_000_000;
   localparam int RANDOM_BYTES = 1750;

   // Keeps a copy of the parser state and the queue of positions still to come out.
   class line_scoreboard;
      logic signed [31:0] held_position;
      logic [6:0]         line_count;
      phase_type          phase;
      logic               negative;
      logic [31:0]        magnitude;
      logic               saturated;
      logic               digits_seen;
      rsp_payload_type    pending_positions[$];
      int                 errors;
      int                 lines;
      int                 numbers;
      int                 saturations;
      int                 wraps;
      int                 checked;

      function new();
         held_position = '0;
         errors = 0;
         lines = 0;
         numbers = 0;
         saturations = 0;
         wraps = 0;
         checked = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_count = '0;
         phase = PhaseSkip;
         negative = 1'b0;
         magnitude = '0;
         saturated = 1'b0;
         digits_seen = 1'b0;
      endfunction

      // Accumulates one digit, pinning the magnitude at the limit of its sign.
      function void take_digit(logic [3:0] digit);
         logic [63:0] limit;
         logic [63:0] next_value;
         digits_seen = 1'b1;
         phase = PhaseDigits;
         if (saturated) return;
         limit = negative ? {32'b0, NegLimit} : {32'b0, PosLimit};
         next_value = {32'b0, magnitude} * 64'd10 + {60'b0, digit};
         if (next_value >= limit) begin
            next_value = limit;
            saturated = 1'b1;
         end
         magnitude = next_value[31:0];
      endfunction

      // Advances the parser by one accepted byte; a newline queues one result.
      function void note_byte(logic [7:0] rx);
         logic            is_digit;
         logic            is_blank;
         rsp_payload_type result;
         if (rx == ByteNewline) begin
            if (digits_seen) begin
               held_position = negative ? -magnitude : magnitude;
               numbers++;
            end
            if (saturated) saturations++;
            result.position = held_position;
            result.number_found = digits_seen;
            pending_positions.push_back(result);
            lines++;
            clear_line();
            return;
         end
         is_digit = (rx >= ByteDigit0) && (rx <= ByteDigit9);
         is_blank = (rx == ByteSpace) || ((rx >= ByteTab) && (rx <= ByteCr));
         case (phase)
            PhaseSkip: begin
               if (!is_blank) begin
                  if ((rx == BytePlus) || (rx == ByteMinus)) begin
                     negative = (rx == ByteMinus);
                     phase = PhaseSign;
                  end else if (is_digit) begin
                     take_digit(rx[3:0]);
                  end else begin
                     phase = PhaseStop;
                  end
               end
            end
            PhaseSign, PhaseDigits: begin
               if (is_digit) take_digit(rx[3:0]);
               else phase = PhaseStop;
            end
            default: ;
         endcase
         // Every byte other than a newline counts toward the line length.
         line_count = line_count + 7'd1;
         if (line_count >= LINE_LIMIT) begin
            wraps++;
            clear_line();
         end
      endfunction

      // Compares one result beat with the oldest queued expectation.
      function void check_result(rsp_payload_type actual);
         rsp_payload_type expected;
         if (pending_positions.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual position %0d found %0b",
                     $time, actual.position, actual.number_found);
            errors++;
            return;
         end
         expected = pending_positions.pop_front();
         checked++;
         if (actual.position !== expected.position) begin
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, expected.position, actual.position);
            errors++;
         end
         if (actual.number_found !== expected.number_found) begin
            $display("%0t: number_found mismatch, expected %0b, actual %0b",
                     $time, expected.number_found, actual.number_found);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   adlp_stream_if #(.payload_type(req_payload_type)) req_chan ();
   adlp_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   ascii_decimal_line_parser #(.LINE_BYTES(LINE_LIMIT)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   line_scoreboard scoreboard;
   int             bytes_sent;
   int             burst_left;
   int             sink_mode;
   int             sink_mode_left;
   int             sink_stall_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sends one byte: idles between bursts, then holds the beat until it is taken.
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.payload <= rx;
      do @(posedge clock); while (!req_chan.ready);
      scoreboard.note_byte(rx);
      bytes_sent++;
      burst_left--;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
   endtask

   function automatic logic [7:0] random_blank();
      case ($urandom_range(0, 4))
         0: return ByteTab;
         1: return 8'd11;
         2: return 8'd12;
         3: return ByteCr;
         default: return ByteSpace;
      endcase
   endfunction

   // One line that holds a number, with optional blanks, sign and trailing junk.
   task automatic send_number_line();
      int pick;
      int digits;
      logic [7:0] junk;
      repeat ($urandom_range(0, 3)) send_byte(random_blank());
      pick = $urandom_range(0, 2);
      if (pick == 1) send_byte(BytePlus);
      else if (pick == 2) send_byte(ByteMinus);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // Near the saturation limits of either sign.
         send_text("214748364");
         send_byte(8'(ByteDigit0 + $urandom_range(5, 9)));
         if ($urandom_range(0, 1)) send_byte(8'(ByteDigit0 + $urandom_range(0, 9)));
      end else begin
         digits = (pick < 8) ? $urandom_range(1, 6) : $urandom_range(7, 14);
         repeat (digits) send_byte(8'(ByteDigit0 + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1)) begin
         repeat ($urandom_range(1, 3)) begin
            junk = 8'($urandom_range(0, 255));
            if (junk == ByteNewline) junk = 8'd0;
            send_byte(junk);
         end
      end
      send_byte(ByteNewline);
   endtask

   // One line of LINE_LIMIT - 5 to LINE_LIMIT + 30 blanks and digits, often longer than the line buffer.
   task automatic send_long_line();
      repeat ($urandom_range(LINE_LIMIT - 5, LINE_LIMIT + 30)) begin
         if ($urandom_range(0, 3) == 0) send_byte(8'(ByteDigit0 + $urandom_range(0, 9)));
         else send_byte(random_blank());
      end
      if ($urandom_range(0, 1)) send_byte(8'(ByteDigit0 + $urandom_range(0, 9)));
      send_byte(ByteNewline);
   endtask

   // Lines without a usable number: empty, lone sign, lone blank, junk first.
   task automatic send_empty_line();
      case ($urandom_range(0, 3))
         0: ;
         1: send_byte($urandom_range(0, 1) ? BytePlus : ByteMinus);
         2: send_byte(random_blank());
         default: send_byte(8'($urandom_range(58, 255)));
      endcase
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 9)));
      send_byte(ByteNewline);
   endtask

   // The receiver switches between free flow, light stalls and long stalls.
   always @(negedge clock) begin
      if (sink_mode_left == 0) begin
         sink_mode = $urandom_range(0, 2);
         sink_mode_left = $urandom_range(20, 120);
      end
      sink_mode_left--;
      case (sink_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 9) < 7);
         default: begin
            if (sink_stall_left > 0) begin
               sink_stall_left--;
               rsp_chan.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
               sink_stall_left = $urandom_range(1, 15);
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      endcase
   end

   // Every result beat is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) scoreboard.check_result(rsp_chan.payload);
   end

   initial begin
      #(RUN_LIMIT);
      $display("testbench failed");
      $finish;
   end

   initial begin
      int kind;
      scoreboard = new();
      bytes_sent = 0;
      burst_left = 0;
      sink_mode = 0;
      sink_mode_left = 0;
      sink_stall_left = 0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines: limits, signs, blanks, stops and the long-line wrap.
      send_text("0\n");
      send_text("+2147483647\n");
      send_text("2147483648\n");
      send_text("-2147483648\n");
      send_text("-2147483649\n");
      send_text("99999999999999\n");
      send_text("-00012\n");
      send_text(" \t+305\n");
      send_byte(8'd11);
      send_byte(8'd12);
      send_byte(ByteCr);
      send_text("-42abc\n");
      send_text("-\n");
      send_text("+\n");
      send_text("\n");
      send_text("x12\n");
      send_text("- 5\n");
      send_text("12");
      send_byte(8'd0);
      send_text(" 34\n");
      send_text("++3\n");
      send_byte(8'd255);
      send_text("\n");
      repeat (LINE_LIMIT - 1) send_byte(ByteSpace);
      send_text("57\n");

      // Random lines, mostly well formed, with noise and long lines mixed in.
      while (bytes_sent < RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            send_number_line();
         end else if (kind < 75) begin
            send_empty_line();
         end else if (kind < 94) begin
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_long_line();
         end
      end
      send_byte(ByteNewline);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (scoreboard.pending_positions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d lines; %0d results checked, %0d held a number.",
               bytes_sent, scoreboard.lines, scoreboard.checked, scoreboard.numbers);
      $display("Lines that saturated: %0d; line buffer wraps: %0d; errors: %0d.",
               scoreboard.saturations, scoreboard.wraps, scoreboard.errors);
      if (scoreboard.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
